[hdl/brightness_contrast_adjust_unit_defines.svh]
// assertion helpers used by the checker of this block
// each expects clk and arst_n in the scope where it is used
`ifndef BRIGHTNESS_CONTRAST_ADJUST_UNIT_DEFINES_SVH
`define BRIGHTNESS_CONTRAST_ADJUST_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define BCA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BCA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/bca_pkg.sv]
`timescale 1ns / 1ps

package bca_pkg;

	// field widths
	localparam int unsigned CH_W = 8;
	localparam int unsigned CFG_W = 9;
	localparam int unsigned GAIN_INT_BITS = 8;
	// width of (channel + brightness - mid), range -384..382
	localparam int unsigned DIFF_W = 10;

	// gain formula constants
	localparam int unsigned GAIN_NUM = 259;
	localparam int unsigned GAIN_SCALE = 255;
	localparam int unsigned C_MID = 128;
	localparam int unsigned CH_MAX = 255;

	// configuration register indexes
	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t REG_BRIGHTNESS = 1'b0;
	localparam cfg_idx_t REG_CONTRAST = 1'b1;

	typedef logic [CH_W-1:0] chan_t;
	typedef logic signed [CFG_W-1:0] cfg_val_t;

endpackage

[hdl/bca_pix_in_if.sv]
`timescale 1ns / 1ps

interface bca_pix_in_if;
	logic valid;
	logic ready;
	bca_pkg::chan_t red_in;
	bca_pkg::chan_t green_in;
	bca_pkg::chan_t blue_in;

	modport source (output valid, output red_in, output green_in, output blue_in,
		input ready);
	modport sink (input valid, input red_in, input green_in, input blue_in,
		output ready);
endinterface

[hdl/bca_pix_out_if.sv]
`timescale 1ns / 1ps

interface bca_pix_out_if;
	logic valid;
	logic ready;
	bca_pkg::chan_t red_out;
	bca_pkg::chan_t green_out;
	bca_pkg::chan_t blue_out;

	modport source (output valid, output red_out, output green_out, output blue_out,
		input ready);
	modport sink (input valid, input red_out, input green_out, input blue_out,
		output ready);
endinterface

[hdl/brightness_contrast_adjust_unit.sv]
`timescale 1ns / 1ps

// Brightness and contrast adjustment, one RGB pixel in and one out per transaction.
// Each channel gets the brightness offset, then gain*(v-128)+128, truncated and
// clamped to 0..255. Pixels stream at one per clock while results are taken and pixel
// ready is not held low, through a three-stage pipeline (offset, gain multiply, clamp
// into the output register); a result is offered once its pixel has passed all three.
// Writing contrast recomputes the gain in a restoring divider that yields one quotient
// bit per cycle: pixel ready stays low from the write until the divider is done. Any
// configuration write also holds pixel ready low in its own cycle. Gain resets to 1.0.
module brightness_contrast_adjust_unit #(
	parameter int unsigned FACTOR_FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	bca_pix_in_if.sink         pixel,
	bca_pix_out_if.source      result,
	input  logic               wr_en,
	input  bca_pkg::cfg_idx_t  wr_index,
	input  bca_pkg::cfg_val_t  wr_data
);

	localparam int unsigned GAIN_W = bca_pkg::GAIN_INT_BITS + FACTOR_FRACTION_BITS;

	bca_pkg::cfg_val_t  brightness_q;
	logic               gain_busy;
	logic               contrast_wr;
	logic [GAIN_W-1:0]  gain;

	assign contrast_wr = wr_en && (wr_index == bca_pkg::REG_CONTRAST);

	// brightness register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= '0;
		end else if (wr_en && (wr_index == bca_pkg::REG_BRIGHTNESS)) begin
			brightness_q <= wr_data;
		end
	end

	// gain from contrast
	bca_gain_unit #(
		.FRAC_BITS (FACTOR_FRACTION_BITS)
	) u_gain (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (contrast_wr),
		.contrast (wr_data),
		.busy     (gain_busy),
		.gain     (gain)
	);

	// pixel datapath
	bca_pixel_pipe #(
		.FRAC_BITS (FACTOR_FRACTION_BITS)
	) u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.hold       (gain_busy || wr_en),
		.brightness (brightness_q),
		.gain       (gain),
		.pixel      (pixel),
		.result     (result)
	);

endmodule

[hdl/bca_gain_unit.sv]
`timescale 1ns / 1ps

module bca_gain_unit #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  bca_pkg::cfg_val_t                       contrast,
	output logic                                    busy,
	output logic [bca_pkg::GAIN_INT_BITS+FRAC_BITS-1:0] gain
);

	localparam int unsigned GAIN_W = bca_pkg::GAIN_INT_BITS + FRAC_BITS;
	// 259 * 510 < 2^18
	localparam int unsigned NBASE_W = 18;
	// 255 * 514 < 2^17
	localparam int unsigned DEN_W = 17;
	localparam int unsigned NUM_W = NBASE_W + FRAC_BITS;
	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic signed [bca_pkg::CFG_W-1:0] c_sat;
	logic signed [bca_pkg::CFG_W:0]   c_ofs;
	logic signed [bca_pkg::CFG_W+1:0] c_rev;
	logic [NBASE_W-1:0]               num_base;
	logic [DEN_W-1:0]                 den;
	logic [NUM_W-1:0]                 dividend;

	logic [NUM_W-1:0] dvd_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [GAIN_W-1:0] gain_q;

	logic [DEN_W:0]   rem_sh;
	logic             q_bit;
	logic [DEN_W:0]   rem_sub;
	logic [NUM_W-1:0] dvd_next;

	// saturate the one pattern below -255, then form numerator and divisor
	always_comb begin
		c_sat = contrast;
		if (contrast == {1'b1, {(bca_pkg::CFG_W-1){1'b0}}}) begin
			c_sat = contrast + bca_pkg::cfg_val_t'(1);
		end
		c_ofs = {c_sat[bca_pkg::CFG_W-1], c_sat}
			+ (bca_pkg::CFG_W+1)'(bca_pkg::GAIN_SCALE);
		c_rev = (bca_pkg::CFG_W+2)'(bca_pkg::GAIN_NUM)
			- {{2{c_sat[bca_pkg::CFG_W-1]}}, c_sat};
		num_base = NBASE_W'(c_ofs[bca_pkg::CFG_W-1:0] * NBASE_W'(bca_pkg::GAIN_NUM));
		den = DEN_W'(c_rev[bca_pkg::CFG_W:0] * DEN_W'(bca_pkg::GAIN_SCALE));
		// rounding: add half the divisor before dividing
		dividend = {num_base, {FRAC_BITS{1'b0}}} + NUM_W'(den >> 1);
	end

	// restoring division step, one quotient bit per cycle
	always_comb begin
		rem_sh = {rem_q, dvd_q[NUM_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		q_bit = (rem_sh >= {1'b0, den_q});
		dvd_next = {dvd_q[NUM_W-2:0], q_bit};
	end

	// divider control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			gain_q <= GAIN_W'(1) << FRAC_BITS;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				gain_q <= dvd_next[GAIN_W-1:0];
			end
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_next;
			rem_q <= q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
		end
	end

	assign busy = busy_q;
	assign gain = gain_q;

endmodule

[hdl/bca_pixel_pipe.sv]
`timescale 1ns / 1ps

module bca_pixel_pipe #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        hold,
	input  bca_pkg::cfg_val_t                           brightness,
	input  logic [bca_pkg::GAIN_INT_BITS+FRAC_BITS-1:0] gain,
	bca_pix_in_if.sink                                  pixel,
	bca_pix_out_if.source                               result
);

	localparam int unsigned GAIN_W = bca_pkg::GAIN_INT_BITS + FRAC_BITS;
	localparam int unsigned P_W = GAIN_W + 1 + bca_pkg::DIFF_W;
	localparam int unsigned T_W = P_W + 1;
	localparam int unsigned SUM_W = bca_pkg::DIFF_W + 1;
	localparam logic [T_W-1:0] MID_FIX = T_W'(bca_pkg::C_MID) << FRAC_BITS;

	bca_pkg::chan_t chan_in [3];

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;
	logic take;

	logic signed [bca_pkg::DIFF_W-1:0] d_s1 [3];
	logic signed [P_W-1:0]             p_s2 [3];
	bca_pkg::chan_t                    o_s3 [3];

	logic signed [GAIN_W:0] gain_s;

	// truncate the fixed-point sum and clamp to 0..255
	function automatic bca_pkg::chan_t clamp_chan(input logic signed [T_W-1:0] t);
		bca_pkg::chan_t r;
		if (t[T_W-1]) begin
			r = '0;
		end else if (t[T_W-2:FRAC_BITS+bca_pkg::CH_W] != '0) begin
			r = bca_pkg::chan_t'(bca_pkg::CH_MAX);
		end else begin
			r = t[FRAC_BITS+bca_pkg::CH_W-1:FRAC_BITS];
		end
		return r;
	endfunction

	// stage advance, each stage moves when it is empty or the next one moves
	assign rdy3 = !v_s3 || result.ready;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign pixel.ready = rdy1 && !hold;
	assign take = pixel.valid && pixel.ready;

	assign chan_in[0] = pixel.red_in;
	assign chan_in[1] = pixel.green_in;
	assign chan_in[2] = pixel.blue_in;
	assign gain_s = $signed({1'b0, gain});

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= take;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// s1: brightness offset and centering, s2: gain multiply, s3: clamp
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (rdy1) begin
				d_s1[i] <= bca_pkg::DIFF_W'($signed({3'b000, chan_in[i]})
					+ $signed({{2{brightness[bca_pkg::CFG_W-1]}}, brightness})
					- SUM_W'(bca_pkg::C_MID));
			end
			if (rdy2) begin
				p_s2[i] <= gain_s * d_s1[i];
			end
			if (rdy3) begin
				o_s3[i] <= clamp_chan($signed({p_s2[i][P_W-1], p_s2[i]})
					+ $signed(MID_FIX));
			end
		end
	end

	assign result.valid = v_s3;
	assign result.red_out = o_s3[0];
	assign result.green_out = o_s3[1];
	assign result.blue_out = o_s3[2];

endmodule

[hdl/bca_checker.sv]
`timescale 1ns / 1ps
`include "brightness_contrast_adjust_unit_defines.svh"

module bca_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              pixel_ready,
	input logic              result_valid,
	input logic              result_ready,
	input bca_pkg::chan_t    red,
	input bca_pkg::chan_t    green,
	input bca_pkg::chan_t    blue,
	input logic              wr_en,
	input bca_pkg::cfg_idx_t wr_index
);

	// a stalled result stays offered
	`BCA_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid, "result dropped while stalled")

	// a stalled result keeps its pixel
	`BCA_ASSERT_NEXT(a_payload_hold, result_valid && !result_ready, $stable(red) && $stable(green) && $stable(blue), "result changed while stalled")

	// no pixel is taken in a configuration cycle
	`BCA_ASSERT_SAME(a_write_blocks, wr_en, !pixel_ready, "pixel taken during a register write")

	// a contrast write starts the gain update, which holds off pixels
	`BCA_ASSERT_NEXT(a_contrast_busy, wr_en && (wr_index == bca_pkg::REG_CONTRAST), !pixel_ready, "pixel taken before gain update")

endmodule

bind brightness_contrast_adjust_unit bca_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pixel_ready  (pixel.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.red          (result.red_out),
	.green        (result.green_out),
	.blue         (result.blue_out),
	.wr_en        (wr_en),
	.wr_index     (wr_index)
);
